[hw/rtl/swcef_pkg.sv]
package swcef_pkg;

  // Field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CHARGE_W = 24;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_OVERLAP    = 2'd2;

  // Configuration reset values
  localparam logic [31:0] WINDOW_LENGTH_RST    = 32'd32;
  localparam logic [31:0] CHARGE_THRESHOLD_RST = 32'd1280;
  localparam logic        ALLOW_OVERLAP_RST    = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FULL_EVICT,
    ST_WRITE,
    ST_READ,
    ST_CHECK
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic full_evict;
    logic write_pulse;
    logic evict;
    logic finish;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic ring_full;
    logic evict_due;
  } dp_status_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] event_start;
    logic signed [TIME_W-1:0] event_end;
    logic [SUM_W-1:0]         peak_charge;
    logic signed [TIME_W-1:0] peak_time;
    logic                     event_valid;
    logic                     window_overflow;
    logic                     frame_last;
  } event_result_t;

endpackage

[hw/rtl/swcef_if.sv]
interface swcef_pulse_if;
  logic valid;
  logic ready;
  logic signed [swcef_pkg::TIME_W-1:0] pulse_time;
  logic signed [swcef_pkg::TIME_W-1:0] reference_time;
  logic [swcef_pkg::CHARGE_W-1:0]      pulse_charge;
  logic                                frame_end;

  modport source (output valid, pulse_time, reference_time, pulse_charge, frame_end,
                  input ready);
  modport sink (input valid, pulse_time, reference_time, pulse_charge, frame_end,
                output ready);
endinterface

interface swcef_event_if;
  logic valid;
  logic ready;
  logic signed [swcef_pkg::TIME_W-1:0] event_start;
  logic signed [swcef_pkg::TIME_W-1:0] event_end;
  logic [swcef_pkg::SUM_W-1:0]         peak_charge;
  logic signed [swcef_pkg::TIME_W-1:0] peak_time;
  logic                                event_valid;
  logic                                window_overflow;
  logic                                frame_last;

  modport source (output valid, event_start, event_end, peak_charge, peak_time,
                  event_valid, window_overflow, frame_last, input ready);
  modport sink (input valid, event_start, event_end, peak_charge, peak_time,
                event_valid, window_overflow, frame_last, output ready);
endinterface

interface swcef_cfg_if;
  logic valid;
  logic ready;
  logic [swcef_pkg::CFG_IDX_W-1:0]  index;
  logic [swcef_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/swcef_out_queue.sv]
module swcef_out_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push0,
  input  logic                     push1,
  input  swcef_pkg::event_result_t data0,
  input  swcef_pkg::event_result_t data1,
  output logic                     room,
  output logic                     out_valid,
  input  logic                     out_ready,
  output swcef_pkg::event_result_t out_data
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  swcef_pkg::event_result_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] cnt;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != '0);
  assign out_data  = entries[rd_ptr];
  // room for the two words a single pulse may produce
  assign room      = (cnt <= CW'(DEPTH - 2));

  // hold the words
  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= data0;
    end
    if (push1) begin
      entries[wr_ptr + PW'(1)] <= data1;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push0) + PW'(push1);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      cnt <= cnt + CW'(push0) + CW'(push1) - CW'(pop);
    end
  end

endmodule

[hw/rtl/swcef_ctrl.sv]
module swcef_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  out_room,
  input  swcef_pkg::dp_status_t status,
  output logic                  in_ready,
  output swcef_pkg::dp_cmd_t    cmd
);

  swcef_pkg::ctrl_state_t state;
  swcef_pkg::ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swcef_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequence one pulse: optional full-ring eviction, store, window trim, event update
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      swcef_pkg::ST_IDLE: begin
        in_ready = out_room;
        if (in_valid && out_room) begin
          cmd.accept = 1'b1;
          state_next = status.ring_full ? swcef_pkg::ST_FULL_EVICT : swcef_pkg::ST_WRITE;
        end
      end
      swcef_pkg::ST_FULL_EVICT: begin
        cmd.full_evict = 1'b1;
        state_next     = swcef_pkg::ST_WRITE;
      end
      swcef_pkg::ST_WRITE: begin
        cmd.write_pulse = 1'b1;
        state_next      = swcef_pkg::ST_READ;
      end
      swcef_pkg::ST_READ: begin
        state_next = swcef_pkg::ST_CHECK;
      end
      swcef_pkg::ST_CHECK: begin
        if (status.evict_due) begin
          cmd.evict = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_next = swcef_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swcef_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/swcef_datapath.sv]
module swcef_datapath #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  swcef_pkg::dp_cmd_t                   cmd,
  output swcef_pkg::dp_status_t                status,
  input  logic signed [swcef_pkg::TIME_W-1:0]  pulse_time,
  input  logic signed [swcef_pkg::TIME_W-1:0]  reference_time,
  input  logic [swcef_pkg::CHARGE_W-1:0]       pulse_charge,
  input  logic                                 frame_end,
  input  logic                                 cfg_write,
  input  logic [swcef_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swcef_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                 push0,
  output logic                                 push1,
  output swcef_pkg::event_result_t             data0,
  output swcef_pkg::event_result_t             data1
);

  localparam int unsigned AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned TW  = swcef_pkg::TIME_W;
  localparam int unsigned QW  = swcef_pkg::CHARGE_W;
  localparam int unsigned SW  = swcef_pkg::SUM_W;
  localparam int unsigned EW  = TW + QW;

  // configuration
  logic [31:0] window_length;
  logic [31:0] charge_threshold;
  logic        allow_overlap;

  // pulse being worked on
  logic [TW-1:0] cur_time;
  logic [QW-1:0] cur_charge;
  logic          cur_last;

  // ring and window state
  logic [EW-1:0] ring [RING_DEPTH];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] sum, sum_next;
  logic          ovf, ovf_next;

  // open and pending event state
  logic          ev_open, ev_open_next;
  logic [TW-1:0] open_start, open_start_next;
  logic [SW-1:0] open_peak, open_peak_next;
  logic [TW-1:0] open_ptime, open_ptime_next;
  logic          pend_valid, pend_valid_next;
  logic [TW-1:0] pend_start, pend_start_next;
  logic [TW-1:0] pend_end, pend_end_next;
  logic [SW-1:0] pend_peak, pend_peak_next;
  logic [TW-1:0] pend_ptime, pend_ptime_next;

  logic [TW-1:0] rd_time;
  logic [QW-1:0] rd_charge;
  logic [AW-1:0] head_inc;
  logic [AW:0]   slot_sum;
  logic [AW-1:0] slot;
  logic [SW-1:0] sum_sub;
  logic [SW:0]   sum_add;
  logic [TW+1:0] age;
  logic          merge;

  assign rd_time   = rd_data[TW-1:0];
  assign rd_charge = rd_data[EW-1:TW];

  assign head_inc = (head == AW'(RING_DEPTH - 1)) ? '0 : head + AW'(1);
  assign slot_sum = (AW+1)'(head) + (AW+1)'(count);
  assign slot     = (slot_sum >= (AW+1)'(RING_DEPTH)) ?
                    AW'(slot_sum - (AW+1)'(RING_DEPTH)) : AW'(slot_sum);
  assign sum_sub  = (sum > SW'(rd_charge)) ? sum - SW'(rd_charge) : '0;
  assign sum_add  = (SW+1)'(sum) + (SW+1)'(cur_charge);

  // age of the oldest stored pulse against the current one
  assign age = {cur_time[TW-1], cur_time[TW-1], cur_time} -
               {rd_time[TW-1], rd_time[TW-1], rd_time};

  assign status.ring_full = (count == CW'(RING_DEPTH));
  assign status.evict_due = (count > CW'(1)) &&
                            ($signed(age) > $signed({2'b00, window_length}));

  assign merge = !allow_overlap && pend_valid &&
                 ($signed(pend_end) > $signed(open_start));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length    <= swcef_pkg::WINDOW_LENGTH_RST;
      charge_threshold <= swcef_pkg::CHARGE_THRESHOLD_RST;
      allow_overlap    <= swcef_pkg::ALLOW_OVERLAP_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        swcef_pkg::CFG_WINDOW_LENGTH:    window_length    <= cfg_data;
        swcef_pkg::CFG_CHARGE_THRESHOLD: charge_threshold <= cfg_data;
        swcef_pkg::CFG_ALLOW_OVERLAP:    allow_overlap    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // latch the accepted pulse as relative time
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_time   <= TW'(pulse_time - reference_time);
      cur_charge <= pulse_charge;
      cur_last   <= frame_end;
    end
  end

  // ring memory: one write port, registered read at the next head
  always_ff @(posedge clk) begin
    if (cmd.write_pulse) begin
      ring[slot] <= {cur_charge, cur_time};
    end
    rd_data <= ring[head_next];
  end

  // next-state logic for window and events
  always_comb begin
    head_next       = head;
    count_next      = count;
    sum_next        = sum;
    ovf_next        = ovf;
    ev_open_next    = ev_open;
    open_start_next = open_start;
    open_peak_next  = open_peak;
    open_ptime_next = open_ptime;
    pend_valid_next = pend_valid;
    pend_start_next = pend_start;
    pend_end_next   = pend_end;
    pend_peak_next  = pend_peak;
    pend_ptime_next = pend_ptime;
    push0           = 1'b0;
    push1           = 1'b0;
    data0           = '0;
    data1           = '0;

    // drop the oldest pulse
    if (cmd.full_evict || cmd.evict) begin
      sum_next   = sum_sub;
      head_next  = head_inc;
      count_next = count - CW'(1);
      if (cmd.full_evict) begin
        ovf_next = 1'b1;
      end
    end

    // add the new pulse, saturating
    if (cmd.write_pulse) begin
      count_next = count + CW'(1);
      sum_next   = sum_add[SW] ? '1 : sum_add[SW-1:0];
    end

    if (cmd.finish) begin
      // open, extend or close the event
      if (sum > charge_threshold) begin
        if (ev_open) begin
          if (sum > open_peak) begin
            open_peak_next  = sum;
            open_ptime_next = rd_time;
          end
        end else begin
          ev_open_next    = 1'b1;
          open_start_next = rd_time;
          open_peak_next  = sum;
          open_ptime_next = rd_time;
        end
      end else if (ev_open) begin
        if (merge) begin
          pend_end_next = cur_time;
          if (open_peak > pend_peak) begin
            pend_peak_next  = open_peak;
            pend_ptime_next = open_ptime;
          end
        end else begin
          if (pend_valid) begin
            push0                 = 1'b1;
            data0.event_start     = pend_start;
            data0.event_end       = pend_end;
            data0.peak_charge     = pend_peak;
            data0.peak_time       = pend_ptime;
            data0.event_valid     = 1'b1;
            data0.window_overflow = ovf;
            data0.frame_last      = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_start_next = open_start;
          pend_end_next   = cur_time;
          pend_peak_next  = open_peak;
          pend_ptime_next = open_ptime;
        end
        ev_open_next   = 1'b0;
        open_peak_next = '0;
      end

      // flush the frame: pending event or empty marker, then clear
      if (cur_last) begin
        data1.event_start     = pend_valid_next ? pend_start_next : '0;
        data1.event_end       = pend_valid_next ? pend_end_next : '0;
        data1.peak_charge     = pend_valid_next ? pend_peak_next : '0;
        data1.peak_time       = pend_valid_next ? pend_ptime_next : '0;
        data1.event_valid     = pend_valid_next;
        data1.window_overflow = ovf;
        data1.frame_last      = 1'b1;
        if (push0) begin
          push1 = 1'b1;
        end else begin
          push0 = 1'b1;
          data0 = data1;
        end
        head_next       = '0;
        count_next      = '0;
        sum_next        = '0;
        ovf_next        = 1'b0;
        ev_open_next    = 1'b0;
        open_start_next = '0;
        open_peak_next  = '0;
        open_ptime_next = '0;
        pend_valid_next = 1'b0;
        pend_start_next = '0;
        pend_end_next   = '0;
        pend_peak_next  = '0;
        pend_ptime_next = '0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      sum        <= '0;
      ovf        <= 1'b0;
      ev_open    <= 1'b0;
      open_start <= '0;
      open_peak  <= '0;
      open_ptime <= '0;
      pend_valid <= 1'b0;
      pend_start <= '0;
      pend_end   <= '0;
      pend_peak  <= '0;
      pend_ptime <= '0;
    end else begin
      head       <= head_next;
      count      <= count_next;
      sum        <= sum_next;
      ovf        <= ovf_next;
      ev_open    <= ev_open_next;
      open_start <= open_start_next;
      open_peak  <= open_peak_next;
      open_ptime <= open_ptime_next;
      pend_valid <= pend_valid_next;
      pend_start <= pend_start_next;
      pend_end   <= pend_end_next;
      pend_peak  <= pend_peak_next;
      pend_ptime <= pend_ptime_next;
    end
  end

endmodule

[hw/rtl/sliding_window_charge_event_finder.sv]
// Sliding-window charge event finder.
// pulses: one word per detector pulse, in time order, valid/ready. Each word
//   carries pulse time, reference time, charge and a frame_end mark.
// events: result words, valid/ready. A closed event leaves when a later event
//   replaces it; the frame_end pulse always yields a last word (the pending
//   event or an empty marker) with frame_last set.
// cfg: register writes (index, data); always ready, write only while idle.
// Sequence: a pulse is accepted in idle, passes an extra eviction state when the
//   ring is full, then goes through the write, read and check states. The check
//   state evicts the pulses that fall out of the window one by one over the single
//   ring read port; the ring read is registered, so a read state sits before the check.
//   Result words enter the output queue from the check state; events shows the queue head.
// Stalls: results sit in a four-word queue. A pulse is taken only with room
//   for two words, so a stalled receiver holds pulses back but loses nothing.
// Reset: clears ring pointers, window sum, events and queue; registers return
//   to window 32, threshold 1280 and merging of overlapping events.
module sliding_window_charge_event_finder #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  swcef_pulse_if.sink  pulses,
  swcef_event_if.source events,
  swcef_cfg_if.sink    cfg
);

  swcef_pkg::dp_cmd_t       cmd;
  swcef_pkg::dp_status_t    status;
  swcef_pkg::event_result_t data0;
  swcef_pkg::event_result_t data1;
  swcef_pkg::event_result_t out_data;
  logic                     push0;
  logic                     push1;
  logic                     out_room;

  assign cfg.ready = 1'b1;

  swcef_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pulses.valid),
    .out_room (out_room),
    .status   (status),
    .in_ready (pulses.ready),
    .cmd      (cmd)
  );

  swcef_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .pulse_time     (pulses.pulse_time),
    .reference_time (pulses.reference_time),
    .pulse_charge   (pulses.pulse_charge),
    .frame_end      (pulses.frame_end),
    .cfg_write      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .push0          (push0),
    .push1          (push1),
    .data0          (data0),
    .data1          (data1)
  );

  swcef_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .data0     (data0),
    .data1     (data1),
    .room      (out_room),
    .out_valid (events.valid),
    .out_ready (events.ready),
    .out_data  (out_data)
  );

  assign events.event_start     = out_data.event_start;
  assign events.event_end       = out_data.event_end;
  assign events.peak_charge     = out_data.peak_charge;
  assign events.peak_time       = out_data.peak_time;
  assign events.event_valid     = out_data.event_valid;
  assign events.window_overflow = out_data.window_overflow;
  assign events.frame_last      = out_data.frame_last;

endmodule

[tb/sliding_window_charge_event_finder_tb.sv]
`timescale 1ns / 1ps

module sliding_window_charge_event_finder_tb;

  localparam int unsigned TIME_W    = swcef_pkg::TIME_W;
  localparam int unsigned CHARGE_W  = swcef_pkg::CHARGE_W;
  localparam int unsigned SUM_W     = swcef_pkg::SUM_W;
  localparam int unsigned CFG_IDX_W = swcef_pkg::CFG_IDX_W;

  localparam int unsigned FINDER_DEPTH   = 256;
  // worst pulse: every stored pulse falls out of the window, plus the full-ring eviction
  localparam int          SETTLE_CYCLES  = FINDER_DEPTH + 8;
  localparam int          LONG_HOLD      = 600;
  localparam int          WATCHDOG_LIMIT = 20000;
  localparam int          SIDE_SEND      = 0;
  localparam int          SIDE_RECV      = 1;

  typedef struct packed {
    logic signed [TIME_W-1:0] pulse_time;
    logic signed [TIME_W-1:0] reference_time;
    logic [CHARGE_W-1:0]      pulse_charge;
    logic                     frame_end;
  } pulse_word_t;

  typedef struct packed {
    pulse_word_t              stim;
    logic                     typed;
    swcef_pkg::event_result_t want;
  } stim_row_t;

  localparam swcef_pkg::event_result_t NO_WANT    = '0;
  localparam swcef_pkg::event_result_t EMPTY_LAST =
    '{32'sd0, 32'sd0, 32'd0, 32'sd0, 1'b0, 1'b0, 1'b1};

  // Directed rows run on the reset register values (window 32, threshold 1280, merging)
  localparam int DIRECTED_ROWS = 20;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // lone frame end straight after reset: empty marker
    '{'{32'sd0, 32'sd0, 24'd0, 1'b1}, 1'b1, EMPTY_LAST},
    // event still open at frame end is dropped, relative time wraps to -1
    '{'{32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 1'b1}, 1'b1, EMPTY_LAST},
    // extreme times and charges, then an out-of-order pulse
    '{'{32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 1'b0}, 1'b0, NO_WANT},
    '{'{32'h8000_0000, 32'h7FFF_FFFF, 24'hFF_FFFF, 1'b0}, 1'b0, NO_WANT},
    '{'{32'sd100,      32'sd0,        24'd0,       1'b0}, 1'b0, NO_WANT},
    '{'{32'sd50,       32'sd0,        24'd2000,    1'b0}, 1'b0, NO_WANT},
    '{'{32'sd200,      32'sd0,        24'd0,       1'b0}, 1'b0, NO_WANT},
    '{'{32'sd300,      32'sd0,        24'd0,       1'b1}, 1'b0, NO_WANT},
    // two overlapping events with equal peaks merge, a sum equal to threshold at frame end opens nothing
    '{'{32'sd0,        32'sd0,        24'd1000,    1'b0}, 1'b0, NO_WANT},
    '{'{32'sd10,       32'sd0,        24'd1000,    1'b0}, 1'b0, NO_WANT},
    '{'{32'sd40,       32'sd0,        24'd0,       1'b0}, 1'b0, NO_WANT},
    '{'{32'sd41,       32'sd0,        24'd1000,    1'b0}, 1'b0, NO_WANT},
    '{'{32'sd80,       32'sd0,        24'd0,       1'b0}, 1'b0, NO_WANT},
    '{'{32'sd90,       32'sd0,        24'd1280,    1'b1}, 1'b0, NO_WANT},
    // sum exactly at threshold never opens an event
    '{'{32'sd0,        32'sd0,        24'd1280,    1'b1}, 1'b1, EMPTY_LAST},
    // negative relative times, then a separate later event
    '{'{-32'sd10,      32'sd5,        24'd2000,    1'b0}, 1'b0, NO_WANT},
    '{'{32'sd20,       32'sd0,        24'd0,       1'b0}, 1'b0, NO_WANT},
    '{'{32'sd1000,     -32'sd1000,    24'h80_0000, 1'b0}, 1'b0, NO_WANT},
    '{'{32'sd2010,     32'sd0,        24'd0,       1'b0}, 1'b0, NO_WANT},
    '{'{32'sd2100,     32'sd0,        24'd0,       1'b1}, 1'b0, NO_WANT}
  };

  logic clk = 1'b0;
  logic rst;

  swcef_pulse_if pulses ();
  swcef_event_if events ();
  swcef_cfg_if   cfg ();

  sliding_window_charge_event_finder #(.RING_DEPTH(FINDER_DEPTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .pulses (pulses),
    .events (events),
    .cfg    (cfg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Finder state as seen by the predictor
  logic [TIME_W-1:0]   held_time   [FINDER_DEPTH];
  logic [CHARGE_W-1:0] held_charge [FINDER_DEPTH];
  int unsigned         oldest_idx;
  int unsigned         held_count;
  logic [SUM_W-1:0]    run_sum;
  logic                ev_open;
  logic [31:0]         ev_start, ev_peak, ev_peak_at;
  logic                pend_valid;
  logic [31:0]         pend_start, pend_end, pend_peak, pend_peak_at;
  logic                ovf_seen;
  logic [31:0]         win_len, thresh;
  logic                keep_apart;

  swcef_pkg::event_result_t events_due [$];
  swcef_pkg::event_result_t due_word;
  int            mismatches = 0;
  int            idle_cycles = 0;
  int            calm_left [2] = '{0, 0};
  logic          long_hold_due = 1'b0;
  logic [31:0]   rel_now;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  // Append one expected event word at the tail
  task automatic enqueue_due(input swcef_pkg::event_result_t res);
    events_due = {events_due, res};
  endtask

  // Mostly short gaps, a few long ones, and calm stretches with none
  function automatic int idle_len(input int side);
    int roll;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      calm_left[side] = $urandom_range(60, 20);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic clear_frame();
    oldest_idx   = 0;
    held_count   = 0;
    run_sum      = '0;
    ev_open      = 1'b0;
    ev_start     = '0;
    ev_peak      = '0;
    ev_peak_at   = '0;
    pend_valid   = 1'b0;
    pend_start   = '0;
    pend_end     = '0;
    pend_peak    = '0;
    pend_peak_at = '0;
    ovf_seen     = 1'b0;
  endtask

  // Remove the oldest stored pulse, flooring the sum at zero
  task automatic drop_oldest();
    logic [SUM_W-1:0] c;
    c = SUM_W'(held_charge[oldest_idx]);
    run_sum = (run_sum > c) ? run_sum - c : '0;
    oldest_idx = (oldest_idx + 1) % FINDER_DEPTH;
    if (held_count > 0) held_count--;
  endtask

  function automatic swcef_pkg::event_result_t pending_word(input logic last);
    swcef_pkg::event_result_t r;
    r.event_start     = pend_start;
    r.event_end       = pend_end;
    r.peak_charge     = pend_peak;
    r.peak_time       = pend_peak_at;
    r.event_valid     = 1'b1;
    r.window_overflow = ovf_seen;
    r.frame_last      = last;
    return r;
  endfunction

  // Apply one accepted pulse; queue the event words it releases when keep is set
  task automatic advance_finder(input pulse_word_t w, input bit keep);
    logic [TIME_W-1:0]        rel;
    logic [TIME_W-1:0]        head_t;
    logic [SUM_W-1:0]         q;
    longint                   span;
    int unsigned              slot;
    swcef_pkg::event_result_t r;
    rel = w.pulse_time - w.reference_time;
    q   = SUM_W'(w.pulse_charge);

    // full ring: evict the oldest and flag the frame
    if (held_count >= FINDER_DEPTH) begin
      drop_oldest();
      ovf_seen = 1'b1;
    end
    slot = (oldest_idx + held_count) % FINDER_DEPTH;
    held_time[slot]   = rel;
    held_charge[slot] = w.pulse_charge;
    held_count++;
    run_sum = (run_sum > ~q) ? '1 : run_sum + q;

    // drop pulses that lie further back than the window
    forever begin
      if (held_count <= 1) break;
      span = longint'($signed(rel)) - longint'($signed(held_time[oldest_idx]));
      if (span <= longint'(win_len)) break;
      drop_oldest();
    end
    head_t = held_time[oldest_idx];

    if (run_sum > thresh) begin
      if (ev_open) begin
        if (run_sum > ev_peak) begin
          ev_peak    = run_sum;
          ev_peak_at = head_t;
        end
      end else begin
        ev_open    = 1'b1;
        ev_start   = head_t;
        ev_peak    = run_sum;
        ev_peak_at = head_t;
      end
    end else if (ev_open) begin
      if (!keep_apart && pend_valid && $signed(pend_end) > $signed(ev_start)) begin
        // fold into the pending event; on equal peaks the earlier one stays
        pend_end = rel;
        if (ev_peak > pend_peak) begin
          pend_peak    = ev_peak;
          pend_peak_at = ev_peak_at;
        end
      end else begin
        if (pend_valid && keep) enqueue_due(pending_word(1'b0));
        pend_start   = ev_start;
        pend_end     = rel;
        pend_peak    = ev_peak;
        pend_peak_at = ev_peak_at;
        pend_valid   = 1'b1;
      end
      ev_open = 1'b0;
      ev_peak = '0;
    end

    // frame end: flush the pending event or send an empty marker
    if (w.frame_end) begin
      if (pend_valid) begin
        r = pending_word(1'b1);
      end else begin
        r = '0;
        r.window_overflow = ovf_seen;
        r.frame_last      = 1'b1;
      end
      if (keep) enqueue_due(r);
      clear_frame();
    end
  endtask

  // Offer one pulse word after a random gap and hold it until taken
  task automatic offer_pulse(input pulse_word_t w, input bit keep);
    int gap;
    gap = idle_len(SIDE_SEND);
    if (gap > 0) begin
      pulses.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pulses.valid          <= 1'b1;
    pulses.pulse_time     <= w.pulse_time;
    pulses.reference_time <= w.reference_time;
    pulses.pulse_charge   <= w.pulse_charge;
    pulses.frame_end      <= w.frame_end;
    @(posedge clk);
    while (!pulses.ready) @(posedge clk);
    advance_finder(w, keep);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      swcef_pkg::CFG_WINDOW_LENGTH:    win_len    = value;
      swcef_pkg::CFG_CHARGE_THRESHOLD: thresh     = value;
      swcef_pkg::CFG_ALLOW_OVERLAP:    keep_apart = value[0];
      default: ;
    endcase
  endtask

  // Let the finder go idle, then load a new register setting
  task automatic drain_and_configure(input logic [31:0] wl, input logic [31:0] thr,
                                     input logic ov);
    pulses.valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(swcef_pkg::CFG_WINDOW_LENGTH, wl);
    write_reg(swcef_pkg::CFG_CHARGE_THRESHOLD, thr);
    write_reg(swcef_pkg::CFG_ALLOW_OVERLAP, {31'd0, ov});
    cfg.valid <= 1'b0;
  endtask

  // Mostly time-ordered pulses with random content, some out-of-order and wild jumps
  task automatic send_random_pulses(input int count, input int step_max, input int charge_max,
                                    input int frame_odds, input int pause_at);
    pulse_word_t w;
    logic [31:0] ref_t;
    int          roll;
    rel_now = $urandom;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        pulses.valid <= 1'b0;
        @(posedge clk);
        while (events_due.size() != 0) @(posedge clk);
      end
      roll = $urandom_range(99);
      if (roll < 5)      rel_now = rel_now - $urandom_range(200);
      else if (roll < 9) rel_now = $urandom;
      else               rel_now = rel_now + $urandom_range(step_max);
      ref_t = $urandom;
      w.reference_time = ref_t;
      w.pulse_time     = rel_now + ref_t;
      roll = $urandom_range(99);
      if (roll < 15)      w.pulse_charge = '0;
      else if (roll < 22) w.pulse_charge = CHARGE_W'($urandom);
      else                w.pulse_charge = CHARGE_W'($urandom_range(charge_max));
      w.frame_end = (i == count - 1) ||
                    (frame_odds != 0 && $urandom_range(frame_odds - 1) == 0);
      offer_pulse(w, 1'b1);
    end
  endtask

  // Receiver: random back-pressure, one long hold when asked
  initial begin : event_drain
    int gap;
    events.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        gap = LONG_HOLD;
      end else begin
        gap = idle_len(SIDE_RECV);
      end
      if (gap > 0) begin
        events.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      events.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each accepted event word with the oldest one due
  always @(posedge clk) begin
    if (!rst && events.valid && events.ready) begin
      if (events_due.size() == 0) begin
        report_mismatch("event word with nothing due", events.event_start, '0);
      end else begin
        due_word = events_due.pop_front();
        check_field("event_start", events.event_start, due_word.event_start);
        check_field("event_end", events.event_end, due_word.event_end);
        check_field("peak_charge", events.peak_charge, due_word.peak_charge);
        check_field("peak_time", events.peak_time, due_word.peak_time);
        check_field("event_valid", 32'(events.event_valid), 32'(due_word.event_valid));
        check_field("window_overflow", 32'(events.window_overflow),
                    32'(due_word.window_overflow));
        check_field("frame_last", 32'(events.frame_last), 32'(due_word.frame_last));
      end
    end
  end

  // Stop the run when no channel has moved a word for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((pulses.valid && pulses.ready) || (events.valid && events.ready) ||
          (cfg.valid && cfg.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sliding_window_charge_event_finder_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    rst                   <= 1'b1;
    pulses.valid          <= 1'b0;
    pulses.pulse_time     <= '0;
    pulses.reference_time <= '0;
    pulses.pulse_charge   <= '0;
    pulses.frame_end      <= 1'b0;
    cfg.valid             <= 1'b0;
    cfg.index             <= swcef_pkg::CFG_WINDOW_LENGTH;
    cfg.data              <= '0;
    clear_frame();
    win_len    = swcef_pkg::WINDOW_LENGTH_RST;
    thresh     = swcef_pkg::CHARGE_THRESHOLD_RST;
    keep_apart = swcef_pkg::ALLOW_OVERLAP_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table on reset values
    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      offer_pulse(DIRECTED[k].stim, !DIRECTED[k].typed);
      if (DIRECTED[k].typed) enqueue_due(DIRECTED[k].want);
    end

    // merging, with the receiver holding off long enough to fill the result queue
    drain_and_configure(32'd64, 32'd3000, 1'b0);
    long_hold_due = 1'b1;
    send_random_pulses(90, 20, 1500, 12, -1);

    // overlapping events kept apart; sender waits for all results midway
    drain_and_configure(32'd40, 32'd2000, 1'b1);
    send_random_pulses(90, 12, 900, 12, 45);

    // zero window and zero threshold
    drain_and_configure(32'd0, 32'd0, 1'b0);
    send_random_pulses(50, 1, 50, 8, -1);

    // widest window, highest threshold
    drain_and_configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_random_pulses(40, 1000, 4000, 8, -1);

    // one long frame that overfills the ring
    drain_and_configure(32'hFFFF_FFFF, 32'h0100_0000, 1'b0);
    send_random_pulses(270, 3, 16'hFFFF, 0, -1);

    pulses.valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sliding_window_charge_event_finder_tb: clean");
    end else begin
      $display("sliding_window_charge_event_finder_tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/swcef_pkg.sv
hw/rtl/swcef_if.sv
hw/rtl/swcef_out_queue.sv
hw/rtl/swcef_ctrl.sv
hw/rtl/swcef_datapath.sv
hw/rtl/sliding_window_charge_event_finder.sv
tb/sliding_window_charge_event_finder_tb.sv
